[rtl/cubic_bspline_segment_sampler_macros.svh]
// Assertion helpers shared by the sampler modules.
// Define NO_ASSERTIONS to compile them out.
`ifndef CUBIC_BSPLINE_SEGMENT_SAMPLER_MACROS_SVH
`define CUBIC_BSPLINE_SEGMENT_SAMPLER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Plain property checked at every rising edge outside reset.
`define CBSS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Same-cycle implication checked at every rising edge outside reset.
`define CBSS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define CBSS_ASSERT(label, clk, rst, prop, msg)
`define CBSS_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/cbss_pkg.sv]
package cbss_pkg;

  localparam int COORD_W           = 32;
  localparam int CFG_W             = 31;
  localparam int CFG_IDX_W         = 1;
  localparam int COORD_FRAC_BITS   = 16;
  localparam int MAX_INTERVALS_DEF = 63;
  localparam int MUL_W             = 34;
  localparam int DIST_W            = 65;

  localparam logic [CFG_W-1:0] SPACING_RESET = CFG_W'(1 << COORD_FRAC_BITS);
  localparam logic [CFG_W-1:0] DEDUPE_RESET  = CFG_W'(((1 << COORD_FRAC_BITS) + 50) / 100);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_SPACING   = 1'b0,
    REG_DEDUPE_THRESHOLD = 1'b1
  } cfg_reg_t;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_DIST, OP_SPSQ, OP_SQ, OP_SEARCH, OP_NPOW, OP_NCUBE,
    OP_DEN, OP_W1, OP_W2, OP_W3, OP_W4, OP_ACC, OP_RND, OP_DIV, OP_DED, OP_CHK,
    OP_KEEP, OP_NEXT, OP_FINISH
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic start_item;
    logic search_done;
    logic acc_done;
    logic div_last;
    logic j_last;
    logic keep;
    logic pend_valid;
    logic out_free;
  } status_t;

endpackage

[rtl/cbss_point_if.sv]
interface cbss_point_if;
  import cbss_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic                      curve_start;

  modport source (output valid, point_x, point_y, curve_start, input ready);
  modport sink (input valid, point_x, point_y, curve_start, output ready);
endinterface

[rtl/cbss_sample_if.sv]
interface cbss_sample_if;
  import cbss_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] sample_x;
  logic signed [COORD_W-1:0] sample_y;
  logic                      segment_end;
  logic                      last_of_run;

  modport source (output valid, sample_x, sample_y, segment_end, last_of_run, input ready);
  modport sink (input valid, sample_x, sample_y, segment_end, last_of_run, output ready);
endinterface

[rtl/cubic_bspline_segment_sampler.sv]
// Uniform cubic B-spline segment sampler.
// point_in carries one control point per beat (signed Q16.16 x and y plus
// curve_start). A curve_start beat clears the point window and the dedupe
// history and yields nothing; the next three points only fill the window.
// Every later point closes a four-point window, and sample_out then delivers
// the segment's samples, one per beat, with segment_end on the first and
// last sample and last_of_run on the final beat for that point.
// The cfg port writes sample_spacing (index 0) and dedupe_threshold (index 1).
// Sequence: a point that only fills the window is accepted without leaving
// idle. A segment point first runs the interval count, whose squared-distance
// search takes at most MAX_INTERVALS - 1 steps, then for every sample the
// weight and weighted-sum steps and the 1-bit-per-cycle rounding divide for
// x and y, plus one closing step; a dropped sample skips only the keep step.
// One point is worked on at a time; the next is taken once all samples of
// the current one are in the output register.
// Reset clears the window, history, config to 1.0 spacing and 0.01
// threshold, and the output register. If the receiver stalls, the finished
// sample waits in the output register and the block holds its next sample.
module cubic_bspline_segment_sampler #(
  parameter int MAX_INTERVALS = cbss_pkg::MAX_INTERVALS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  cbss_point_if.sink                     point_in,
  cbss_sample_if.source                  sample_out,
  input  logic                           cfg_we,
  input  logic [cbss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cbss_pkg::CFG_W-1:0]     cfg_data
);
  import cbss_pkg::*;

  cmd_t    cmd;
  status_t st;

  cbss_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_in.valid),
    .point_ready (point_in.ready),
    .st          (st),
    .cmd         (cmd)
  );

  cbss_datapath #(
    .MAX_INTERVALS (MAX_INTERVALS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pt_x       (point_in.point_x),
    .pt_y       (point_in.point_y),
    .pt_start   (point_in.curve_start),
    .cmd        (cmd),
    .st         (st),
    .sample_out (sample_out)
  );

endmodule

[rtl/cbss_ctrl.sv]
`include "cubic_bspline_segment_sampler_macros.svh"
module cbss_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             point_valid,
  output logic             point_ready,
  input  cbss_pkg::status_t st,
  output cbss_pkg::cmd_t    cmd
);
  import cbss_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DIST, S_SPSQ, S_SQ, S_SEARCH, S_NPOW, S_NCUBE, S_DEN,
    S_W1, S_W2, S_W3, S_W4, S_ACC, S_RND, S_DIV, S_DED, S_CHK, S_KEEP,
    S_NEXT, S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   push_wait;

  // A pending sample can only move on when the output register has room.
  assign push_wait   = st.pend_valid && !st.out_free;
  assign point_ready = (state == S_IDLE);

  // Operation for the current state.
  always_comb begin
    cmd.op = OP_NONE;
    unique case (state)
      S_IDLE:   cmd.op = point_valid ? OP_ACCEPT : OP_NONE;
      S_DIST:   cmd.op = OP_DIST;
      S_SPSQ:   cmd.op = OP_SPSQ;
      S_SQ:     cmd.op = OP_SQ;
      S_SEARCH: cmd.op = OP_SEARCH;
      S_NPOW:   cmd.op = OP_NPOW;
      S_NCUBE:  cmd.op = OP_NCUBE;
      S_DEN:    cmd.op = OP_DEN;
      S_W1:     cmd.op = OP_W1;
      S_W2:     cmd.op = OP_W2;
      S_W3:     cmd.op = OP_W3;
      S_W4:     cmd.op = OP_W4;
      S_ACC:    cmd.op = OP_ACC;
      S_RND:    cmd.op = OP_RND;
      S_DIV:    cmd.op = OP_DIV;
      S_DED:    cmd.op = OP_DED;
      S_CHK:    cmd.op = OP_CHK;
      S_KEEP:   cmd.op = push_wait ? OP_NONE : OP_KEEP;
      S_NEXT:   cmd.op = st.j_last ? OP_NONE : OP_NEXT;
      S_FINISH: cmd.op = push_wait ? OP_NONE : OP_FINISH;
      default:  cmd.op = OP_NONE;
    endcase
  end

  // Sequencing of one segment: interval count, then per sample weights,
  // weighted sums, rounding divide and the distance filter.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (point_valid && st.start_item) state_next = S_DIST;
      S_DIST:   state_next = S_SPSQ;
      S_SPSQ:   state_next = S_SQ;
      S_SQ:     state_next = S_SEARCH;
      S_SEARCH: if (st.search_done) state_next = S_NPOW;
      S_NPOW:   state_next = S_NCUBE;
      S_NCUBE:  state_next = S_DEN;
      S_DEN:    state_next = S_W1;
      S_W1:     state_next = S_W2;
      S_W2:     state_next = S_W3;
      S_W3:     state_next = S_W4;
      S_W4:     state_next = S_ACC;
      S_ACC:    if (st.acc_done) state_next = S_RND;
      S_RND:    state_next = S_DIV;
      S_DIV:    if (st.div_last) state_next = S_DED;
      S_DED:    state_next = S_CHK;
      S_CHK:    state_next = st.keep ? S_KEEP : S_NEXT;
      S_KEEP:   if (!push_wait) state_next = S_NEXT;
      S_NEXT:   state_next = st.j_last ? S_FINISH : S_W1;
      S_FINISH: if (!push_wait) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `CBSS_ASSERT(a_start_goes_dist, clk, rst, (point_valid && point_ready && st.start_item) |=> (state == S_DIST), "segment start did not begin distance step")
  `CBSS_ASSERT_IMP(a_push_room, clk, rst, (cmd.op == OP_KEEP) && st.pend_valid, st.out_free, "push into a full output register")

endmodule

[rtl/cbss_datapath.sv]
`include "cubic_bspline_segment_sampler_macros.svh"
module cbss_datapath #(
  parameter int MAX_INTERVALS = cbss_pkg::MAX_INTERVALS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [cbss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cbss_pkg::CFG_W-1:0]        cfg_data,
  input  logic signed [cbss_pkg::COORD_W-1:0] pt_x,
  input  logic signed [cbss_pkg::COORD_W-1:0] pt_y,
  input  logic                              pt_start,
  input  cbss_pkg::cmd_t                    cmd,
  output cbss_pkg::status_t                 st,
  cbss_sample_if.source                     sample_out
);
  import cbss_pkg::*;

  localparam int N_W    = $clog2(MAX_INTERVALS + 1);
  localparam int DEN_W  = $clog2(6 * MAX_INTERVALS * MAX_INTERVALS * MAX_INTERVALS + 1);
  localparam int ACC_W  = DEN_W + COORD_W + 1;
  localparam int NUM_W  = DEN_W + COORD_W;
  localparam int SQ_W   = 2 * N_W + 2 * CFG_W;
  localparam int WT_W   = DEN_W + 4;
  localparam int PROD_W = 2 * MUL_W;

  function automatic logic [COORD_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                  input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    begin
      d = (COORD_W+1)'(a) - (COORD_W+1)'(b);
      return d[COORD_W] ? COORD_W'(-d) : COORD_W'(d);
    end
  endfunction

  // Configuration and history.
  logic [CFG_W-1:0]          spacing;
  logic [CFG_W-1:0]          threshold;
  logic signed [COORD_W-1:0] win_x [3];
  logic signed [COORD_W-1:0] win_y [3];
  logic signed [COORD_W-1:0] p3_x, p3_y;
  logic [1:0]                fill;
  logic signed [COORD_W-1:0] prev_x, prev_y;
  logic                      prev_valid;

  // Shared multiplier lanes.
  logic signed [MUL_W-1:0]   mul_ax, mul_bx, mul_ay, mul_by;
  logic signed [PROD_W-1:0]  prod_x, prod_y;

  // Segment constants.
  logic [DIST_W-1:0]         seg_d2;
  logic [2*CFG_W-1:0]        sp2, thr2;
  logic [SQ_W-1:0]           sq_acc, sq_inc;
  logic [N_W-1:0]            k, n, j;
  logic [2*N_W-1:0]          n2, j2;
  logic [3*N_W-1:0]          n3, j3, m3;
  logic [DEN_W-1:0]          den;
  logic [DEN_W-1:0]          w [4];
  logic [2:0]                idx;
  logic signed [ACC_W-1:0]   acc_x, acc_y;
  logic                      neg_x, neg_y;
  logic [DEN_W-1:0]          rem_x, rem_y;
  logic [COORD_W-1:0]        dq_x, dq_y;
  logic [4:0]                dcnt;

  // Candidate and output holding.
  logic signed [COORD_W-1:0] pend_x, pend_y;
  logic                      pend_end, pend_valid;
  logic signed [COORD_W-1:0] out_x, out_y;
  logic                      out_end, out_last, out_valid;
  logic                      out_free, push;

  // Combinational helpers.
  logic [N_W-1:0]            m;
  logic                      search_done;
  logic signed [COORD_W-1:0] sel_x, sel_y;
  logic signed [COORD_W-1:0] smp_x, smp_y;
  logic [ACC_W-1:0]          mag_x, mag_y;
  logic [NUM_W-1:0]          num_x, num_y;
  logic [DEN_W:0]            dt_x, dt_y;
  logic                      ge_x, ge_y;
  logic [DIST_W-1:0]         ded_d2;
  logic                      keep;
  logic signed [WT_W-1:0]    a_n3, a_j3, a_nj2, a_n2j, w1s, w2s;

  assign m           = n - j;
  assign search_done = (k == N_W'(MAX_INTERVALS - 1)) || (sq_acc > SQ_W'(seg_d2));
  assign smp_x       = neg_x ? $signed(-dq_x) : $signed(dq_x);
  assign smp_y       = neg_y ? $signed(-dq_y) : $signed(dq_y);
  assign mag_x       = acc_x[ACC_W-1] ? ACC_W'(-acc_x) : ACC_W'(acc_x);
  assign mag_y       = acc_y[ACC_W-1] ? ACC_W'(-acc_y) : ACC_W'(acc_y);
  assign num_x       = NUM_W'(mag_x) + NUM_W'(den >> 1);
  assign num_y       = NUM_W'(mag_y) + NUM_W'(den >> 1);
  assign dt_x        = {rem_x, dq_x[COORD_W-1]};
  assign dt_y        = {rem_y, dq_y[COORD_W-1]};
  assign ge_x        = dt_x >= {1'b0, den};
  assign ge_y        = dt_y >= {1'b0, den};
  assign ded_d2      = DIST_W'(prod_x[2*COORD_W-1:0]) + DIST_W'(prod_y[2*COORD_W-1:0]);
  assign keep        = !prev_valid || (ded_d2 >= DIST_W'(thr2));
  assign out_free    = !out_valid || sample_out.ready;
  assign push        = ((cmd.op == OP_KEEP) || (cmd.op == OP_FINISH)) && pend_valid;

  // Basis weights from the lane products of the previous cycle.
  assign a_n3  = WT_W'(n3);
  assign a_j3  = WT_W'(j3);
  assign a_nj2 = WT_W'(prod_x[3*N_W-1:0]);
  assign a_n2j = WT_W'(prod_y[3*N_W-1:0]);
  assign w1s   = (a_n3 <<< 2) - a_nj2 * WT_W'(6) + a_j3 * WT_W'(3);
  assign w2s   = a_n3 + a_n2j * WT_W'(3) + a_nj2 * WT_W'(3) - a_j3 * WT_W'(3);

  // Control point of the current weighted-sum term.
  always_comb begin
    unique case (idx[1:0])
      2'd0:    begin sel_x = win_x[0]; sel_y = win_y[0]; end
      2'd1:    begin sel_x = win_x[1]; sel_y = win_y[1]; end
      2'd2:    begin sel_x = win_x[2]; sel_y = win_y[2]; end
      default: begin sel_x = p3_x;     sel_y = p3_y;     end
    endcase
  end

  // Operand selection for both multiplier lanes.
  always_comb begin
    mul_ax = '0;
    mul_bx = '0;
    mul_ay = '0;
    mul_by = '0;
    unique case (cmd.op)
      OP_DIST: begin
        mul_ax = MUL_W'(abs_diff(win_x[2], win_x[1]));
        mul_bx = MUL_W'(abs_diff(win_x[2], win_x[1]));
        mul_ay = MUL_W'(abs_diff(win_y[2], win_y[1]));
        mul_by = MUL_W'(abs_diff(win_y[2], win_y[1]));
      end
      OP_SPSQ: begin
        mul_ax = MUL_W'(spacing);
        mul_bx = MUL_W'(spacing);
        mul_ay = MUL_W'(threshold);
        mul_by = MUL_W'(threshold);
      end
      OP_NPOW: begin
        mul_ax = MUL_W'(n);
        mul_bx = MUL_W'(n);
      end
      OP_NCUBE: begin
        mul_ax = MUL_W'(prod_x[2*N_W-1:0]);
        mul_bx = MUL_W'(n);
      end
      OP_W1: begin
        mul_ax = MUL_W'(j);
        mul_bx = MUL_W'(j);
        mul_ay = MUL_W'(m);
        mul_by = MUL_W'(m);
      end
      OP_W2: begin
        mul_ax = MUL_W'(prod_x[2*N_W-1:0]);
        mul_bx = MUL_W'(j);
        mul_ay = MUL_W'(prod_y[2*N_W-1:0]);
        mul_by = MUL_W'(m);
      end
      OP_W3: begin
        mul_ax = MUL_W'(n);
        mul_bx = MUL_W'(j2);
        mul_ay = MUL_W'(n2);
        mul_by = MUL_W'(j);
      end
      OP_ACC: begin
        mul_ax = MUL_W'(w[idx[1:0]]);
        mul_bx = MUL_W'(sel_x);
        mul_ay = MUL_W'(w[idx[1:0]]);
        mul_by = MUL_W'(sel_y);
      end
      OP_DED: begin
        mul_ax = MUL_W'(abs_diff(smp_x, prev_x));
        mul_bx = MUL_W'(abs_diff(smp_x, prev_x));
        mul_ay = MUL_W'(abs_diff(smp_y, prev_y));
        mul_by = MUL_W'(abs_diff(smp_y, prev_y));
      end
      default: ;
    endcase
  end

  // Control state: configuration, fill level, history and beat valids.
  always_ff @(posedge clk) begin
    if (rst) begin
      spacing    <= SPACING_RESET;
      threshold  <= DEDUPE_RESET;
      fill       <= '0;
      prev_valid <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_SAMPLE_SPACING) begin
          spacing <= cfg_data;
        end else begin
          threshold <= cfg_data;
        end
      end
      if (cmd.op == OP_ACCEPT) begin
        if (pt_start) begin
          fill       <= '0;
          prev_valid <= 1'b0;
        end else if (fill != 2'd3) begin
          fill <= fill + 2'd1;
        end
      end
      if (cmd.op == OP_KEEP) begin
        pend_valid <= 1'b1;
        prev_valid <= 1'b1;
      end
      if (cmd.op == OP_FINISH) begin
        pend_valid <= 1'b0;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (sample_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Arithmetic and payload registers.
  always_ff @(posedge clk) begin
    prod_x <= mul_ax * mul_bx;
    prod_y <= mul_ay * mul_by;
    unique case (cmd.op)
      OP_ACCEPT: begin
        if (!pt_start && fill != 2'd3) begin
          win_x[fill] <= pt_x;
          win_y[fill] <= pt_y;
        end
        p3_x <= pt_x;
        p3_y <= pt_y;
      end
      OP_SPSQ: seg_d2 <= DIST_W'(prod_x[2*COORD_W-1:0]) + DIST_W'(prod_y[2*COORD_W-1:0]);
      OP_SQ: begin
        sp2    <= prod_x[2*CFG_W-1:0];
        thr2   <= prod_y[2*CFG_W-1:0];
        sq_acc <= SQ_W'(prod_x[2*CFG_W-1:0]);
        sq_inc <= SQ_W'({prod_x[2*CFG_W-1:0], 1'b0}) + SQ_W'(prod_x[2*CFG_W-1:0]);
        k      <= '0;
      end
      OP_SEARCH: begin
        if (search_done) begin
          n <= (k == '0) ? N_W'(2) : k + N_W'(1);
        end else begin
          k      <= k + N_W'(1);
          sq_acc <= sq_acc + sq_inc;
          sq_inc <= sq_inc + SQ_W'({sp2, 1'b0});
        end
      end
      OP_NCUBE: n2 <= prod_x[2*N_W-1:0];
      OP_DEN: begin
        n3  <= prod_x[3*N_W-1:0];
        den <= DEN_W'({prod_x[3*N_W-1:0], 2'b00}) + DEN_W'({prod_x[3*N_W-1:0], 1'b0});
        j   <= '0;
      end
      OP_W2: begin
        j2 <= prod_x[2*N_W-1:0];
      end
      OP_W3: begin
        j3 <= prod_x[3*N_W-1:0];
        m3 <= prod_y[3*N_W-1:0];
      end
      OP_W4: begin
        w[0] <= DEN_W'(m3);
        w[1] <= DEN_W'(w1s);
        w[2] <= DEN_W'(w2s);
        w[3] <= DEN_W'(j3);
        idx  <= '0;
      end
      OP_ACC: begin
        if (idx == 3'd0) begin
          acc_x <= '0;
          acc_y <= '0;
        end else begin
          acc_x <= acc_x + ACC_W'(prod_x);
          acc_y <= acc_y + ACC_W'(prod_y);
        end
        idx <= idx + 3'd1;
      end
      OP_RND: begin
        neg_x <= acc_x[ACC_W-1];
        neg_y <= acc_y[ACC_W-1];
        rem_x <= num_x[NUM_W-1:COORD_W];
        rem_y <= num_y[NUM_W-1:COORD_W];
        dq_x  <= num_x[COORD_W-1:0];
        dq_y  <= num_y[COORD_W-1:0];
        dcnt  <= '0;
      end
      OP_DIV: begin
        rem_x <= ge_x ? DEN_W'(dt_x - {1'b0, den}) : DEN_W'(dt_x);
        rem_y <= ge_y ? DEN_W'(dt_y - {1'b0, den}) : DEN_W'(dt_y);
        dq_x  <= {dq_x[COORD_W-2:0], ge_x};
        dq_y  <= {dq_y[COORD_W-2:0], ge_y};
        dcnt  <= dcnt + 5'd1;
      end
      OP_KEEP: begin
        pend_x   <= smp_x;
        pend_y   <= smp_y;
        pend_end <= (j == '0) || (j == n);
        prev_x   <= smp_x;
        prev_y   <= smp_y;
      end
      OP_NEXT: j <= j + N_W'(1);
      OP_FINISH: begin
        win_x[0] <= win_x[1];
        win_y[0] <= win_y[1];
        win_x[1] <= win_x[2];
        win_y[1] <= win_y[2];
        win_x[2] <= p3_x;
        win_y[2] <= p3_y;
      end
      default: ;
    endcase
    // Pending sample moves to the output register.
    if (push) begin
      out_x    <= pend_x;
      out_y    <= pend_y;
      out_end  <= pend_end;
      out_last <= (cmd.op == OP_FINISH);
    end
  end

  assign st.start_item  = !pt_start && (fill == 2'd3);
  assign st.search_done = search_done;
  assign st.acc_done    = (idx == 3'd4);
  assign st.div_last    = (dcnt == 5'd31);
  assign st.j_last      = (j == n);
  assign st.keep        = keep;
  assign st.pend_valid  = pend_valid;
  assign st.out_free    = out_free;

  assign sample_out.valid       = out_valid;
  assign sample_out.sample_x    = out_x;
  assign sample_out.sample_y    = out_y;
  assign sample_out.segment_end = out_end;
  assign sample_out.last_of_run = out_last;

  `CBSS_ASSERT(a_keep_sets_prev, clk, rst, (cmd.op == OP_KEEP) |=> (pend_valid && prev_valid), "kept sample not recorded")
  `CBSS_ASSERT_IMP(a_n_range, clk, rst, cmd.op == OP_DEN, (n >= N_W'(2)) && (n <= N_W'(MAX_INTERVALS)), "interval count out of range")
  `CBSS_ASSERT_IMP(a_div_rem, clk, rst, cmd.op == OP_DED, (rem_x < den) && (rem_y < den), "divider remainder not below divisor")

endmodule

[tb/sv/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cbss_pkg::*;

  localparam int MAX_N       = MAX_INTERVALS_DEF;
  localparam int IDLE_LIMIT  = 40000;
  localparam int SETTLE_CYC  = 4000;
  localparam int HOLD_CYC    = 3000;
  localparam int RAND_ITEMS  = 350;

  typedef struct {
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic                      seg_end;
    logic                      tail;
  } sample_t;

  // One row of the directed table; n_exp < 0 leaves the row to the predictor.
  typedef struct {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic                      cs;
    int                        n_exp;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
  } row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  cbss_point_if  pin();
  cbss_sample_if sout();

  cubic_bspline_segment_sampler DUT (
    .clk        (clk),
    .rst        (rst),
    .point_in   (pin),
    .sample_out (sout),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Predictor state: point window, dedupe history and register copies.
  longint win_x [3];
  longint win_y [3];
  int     win_fill;
  longint hist_x;
  longint hist_y;
  bit     hist_ok;
  logic [CFG_W-1:0] spacing_q;
  logic [CFG_W-1:0] thresh_q;

  sample_t samples_due[$];
  int  err_cnt;
  int  src_idle;
  int  snk_idle;
  bit  hold_req;
  int  idle_cycles;

  function automatic logic [64:0] sq_dist(longint ax, longint ay, longint bx, longint by);
    logic [63:0] dx;
    logic [63:0] dy;
    logic [64:0] sum;
    dx = (ax >= bx) ? 64'(ax - bx) : 64'(bx - ax);
    dy = (ay >= by) ? 64'(ay - by) : 64'(by - ay);
    sum = 65'(dx * dx) + 65'(dy * dy);
    return sum;
  endfunction

  function automatic longint div_round(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  // Works out the samples one accepted point causes and queues them.
  function automatic int predict_samples(logic signed [COORD_W-1:0] px,
                                         logic signed [COORD_W-1:0] py, logic cs);
    logic [64:0]  seg_d;
    logic [127:0] stp;
    logic [64:0]  thr2;
    longint n, j, m, den, w0, w1, w2, w3, sx, sy;
    int k;
    sample_t run[$];
    sample_t s;
    if (cs) begin
      win_fill = 0;
      hist_ok = 0;
      return 0;
    end
    if (win_fill < 3) begin
      win_x[win_fill] = px;
      win_y[win_fill] = py;
      win_fill++;
      return 0;
    end
    // Interval count from the exact distance between the middle points.
    seg_d = sq_dist(win_x[2], win_y[2], win_x[1], win_y[1]);
    k = 0;
    while (k < MAX_N - 1) begin
      stp = 128'(k + 1) * 128'(spacing_q);
      if (stp * stp > 128'(seg_d)) break;
      k++;
    end
    n = k + 1;
    if (n < 2) n = 2;
    den = 6 * n * n * n;
    thr2 = 65'(64'(thresh_q) * 64'(thresh_q));
    for (j = 0; j <= n; j++) begin
      m = n - j;
      w0 = m * m * m;
      w1 = 4 * n * n * n - 6 * n * j * j + 3 * j * j * j;
      w2 = n * n * n + 3 * n * n * j + 3 * n * j * j - 3 * j * j * j;
      w3 = j * j * j;
      sx = div_round(w0 * win_x[0] + w1 * win_x[1] + w2 * win_x[2] + w3 * longint'(px), den);
      sy = div_round(w0 * win_y[0] + w1 * win_y[1] + w2 * win_y[2] + w3 * longint'(py), den);
      if (hist_ok && sq_dist(sx, sy, hist_x, hist_y) < thr2) continue;
      s.sx = sx[31:0];
      s.sy = sy[31:0];
      s.seg_end = (j == 0 || j == n);
      s.tail = 1'b0;
      run.insert(run.size(), s);
      hist_x = sx;
      hist_y = sy;
      hist_ok = 1;
    end
    if (run.size() > 0) run[run.size()-1].tail = 1'b1;
    foreach (run[i]) samples_due.insert(samples_due.size(), run[i]);
    win_x[0] = win_x[1];
    win_y[0] = win_y[1];
    win_x[1] = win_x[2];
    win_y[1] = win_y[2];
    win_x[2] = px;
    win_y[2] = py;
    return run.size();
  endfunction

  task automatic note_error(string what);
    err_cnt++;
    if (err_cnt <= 10) $display("mismatch: %s", what);
  endtask

  // Offers one point beat, with random gaps, and predicts once it is taken.
  task automatic send_point(logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py,
                            logic cs, output int cnt);
    while ($urandom_range(99) < src_idle) begin
      pin.valid <= 1'b0;
      @(posedge clk);
    end
    pin.valid       <= 1'b1;
    pin.point_x     <= px;
    pin.point_y     <= py;
    pin.curve_start <= cs;
    @(posedge clk);
    while (!pin.ready) @(posedge clk);
    cnt = predict_samples(px, py, cs);
  endtask

  // Waits for all queued samples, then for any point that yields nothing.
  task automatic settle();
    pin.valid <= 1'b0;
    @(posedge clk);
    while (samples_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SAMPLE_SPACING) spacing_q = value;
    else thresh_q = value;
  endtask

  // Receiver: random backpressure, plus one long hold-off on request.
  initial begin
    sout.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        sout.ready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
        hold_req = 0;
      end else begin
        sout.ready <= ($urandom_range(99) >= snk_idle);
      end
    end
  end

  // Checks each sample beat against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && sout.valid && sout.ready) begin
      if (samples_due.size() == 0) begin
        note_error($sformatf("unexpected sample x=%0d y=%0d", sout.sample_x, sout.sample_y));
      end else begin
        sample_t e;
        e = samples_due.pop_front();
        if (sout.sample_x !== e.sx || sout.sample_y !== e.sy ||
            sout.segment_end !== e.seg_end || sout.last_of_run !== e.tail)
          note_error($sformatf("exp x=%0d y=%0d end=%0b last=%0b got x=%0d y=%0d end=%0b last=%0b",
                               e.sx, e.sy, e.seg_end, e.tail, sout.sample_x,
                               sout.sample_y, sout.segment_end, sout.last_of_run));
      end
    end
  end

  // Watchdog on cycles with no beat on either channel.
  always @(posedge clk) begin
    if (rst || (pin.valid && pin.ready) || (sout.valid && sout.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    row_t rows[$];
    int cnt;
    int items;
    int ph;
    int len;
    longint cx, cy, d;
    logic signed [COORD_W-1:0] px, py;
    logic [CFG_W-1:0] sp_tab [5];
    logic [CFG_W-1:0] th_tab [5];
    int per_phase [5];

    err_cnt = 0;
    src_idle = 24;
    snk_idle = 55;
    hold_req = 0;
    idle_cycles = 0;
    win_x = '{0, 0, 0};
    win_y = '{0, 0, 0};
    win_fill = 0;
    hist_x = 0;
    hist_y = 0;
    hist_ok = 0;
    spacing_q = SPACING_RESET;
    thresh_q = DEDUPE_RESET;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_SAMPLE_SPACING;
    cfg_data <= '0;
    pin.valid <= 1'b0;
    pin.point_x <= '0;
    pin.point_y <= '0;
    pin.curve_start <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part with reset settings. Points before any curve start form
    // a curve begun at reset; four equal points leave one sample after dedupe.
    rows = '{
      '{32'sd0, 32'sd0, 1'b0, 0, 0, 0},
      '{32'sd0, 32'sd0, 1'b0, 0, 0, 0},
      '{32'sd0, 32'sd0, 1'b0, 0, 0, 0},
      '{32'sd0, 32'sd0, 1'b0, 1, 0, 0},
      '{32'sh7FFFFFFF, 32'sh80000000, 1'b1, 0, 0, 0},
      '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0, 0, 0, 0},
      '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0, 0, 0, 0},
      '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0, 0, 0, 0},
      '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0, 1, 32'sh7FFFFFFF, 32'sh7FFFFFFF},
      '{32'sh80000000, 32'sh80000000, 1'b0, -1, 0, 0},
      '{32'sh7FFFFFFF, 32'sh80000000, 1'b0, -1, 0, 0},
      '{32'sh80000000, 32'sh7FFFFFFF, 1'b0, -1, 0, 0},
      '{32'sh00000000, 32'sh00000000, 1'b1, 0, 0, 0},
      '{32'sh80000000, 32'sh80000000, 1'b0, 0, 0, 0},
      '{32'sh80000000, 32'sh80000000, 1'b0, 0, 0, 0},
      '{32'sh80000000, 32'sh80000000, 1'b0, 0, 0, 0},
      '{32'sh80000000, 32'sh80000000, 1'b0, 1, 32'sh80000000, 32'sh80000000},
      '{32'sh00010000, 32'sh00000000, 1'b0, -1, 0, 0},
      '{32'sh00020000, 32'sh00008000, 1'b0, -1, 0, 0},
      '{32'sh00020000, 32'sh00008000, 1'b0, -1, 0, 0},
      '{32'shFFFF0000, 32'sh00000001, 1'b0, -1, 0, 0}
    };
    foreach (rows[i]) begin
      send_point(rows[i].px, rows[i].py, rows[i].cs, cnt);
      if (rows[i].n_exp >= 0 && cnt != rows[i].n_exp)
        note_error($sformatf("row %0d: %0d samples predicted, table says %0d",
                             i, cnt, rows[i].n_exp));
      if (rows[i].n_exp == 1 && (samples_due[$].sx !== rows[i].ex ||
                                 samples_due[$].sy !== rows[i].ey))
        note_error($sformatf("row %0d: table sample differs from prediction", i));
    end
    settle();

    // Random phases over several register settings, extremes included.
    sp_tab = '{31'h00100000, 31'h7FFFFFFF, 31'd1, 31'h00040000, SPACING_RESET};
    th_tab = '{31'd0, 31'h7FFFFFFF, DEDUPE_RESET, 31'h00010000, 31'd300};
    per_phase = '{100, 70, 15, 100, 65};
    items = 0;
    for (ph = 0; ph < 5; ph++) begin
      write_reg(REG_SAMPLE_SPACING, sp_tab[ph]);
      write_reg(REG_DEDUPE_THRESHOLD, th_tab[ph]);
      cx = $signed($urandom);
      cy = $signed($urandom);
      len = 0;
      for (int it = 0; it < per_phase[ph]; it++) begin
        if (items < 120) begin
          src_idle = 24;
          snk_idle = 55;
        end else if (items < 240) begin
          src_idle = 55;
          snk_idle = 24;
        end else begin
          src_idle = 0;
          snk_idle = 0;
        end
        if (ph == 0 && it == 50) hold_req = 1;
        if ($urandom_range(99) < 12) begin
          // Noise: any value, with an occasional stray curve start.
          px = $urandom;
          py = $urandom;
          send_point(px, py, ($urandom_range(9) == 0), cnt);
        end else if (len == 0) begin
          send_point($urandom, $urandom, 1'b1, cnt);
          len = $urandom_range(4, 10);
        end else begin
          // Well-formed curve: each point a few spacings from the last.
          d = longint'(spacing_q) * $urandom_range(0, 4) + $urandom_range(0, 255);
          cx = ($urandom_range(1)) ? cx + d : cx - d;
          d = longint'(spacing_q) * $urandom_range(0, 3) + $urandom_range(0, 255);
          cy = ($urandom_range(1)) ? cy + d : cy - d;
          px = cx[31:0];
          py = cy[31:0];
          cx = px;
          cy = py;
          send_point(px, py, 1'b0, cnt);
          len--;
        end
        items++;
      end
      settle();
    end

    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
